// ----- sv/isbc_pkg.sv -----
// Shared widths, payload types and pipeline records for the IMU still-bias calibration unit.
`timescale 1ns / 1ps

package isbc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 24;
    localparam int MAG_W     = 23;   // |window sum| stays below 2**23 for any window up to 255
    localparam int CORR_W    = 17;
    localparam int LIMIT_W   = 24;
    localparam int COUNT_W   = 8;
    localparam int GYRO_AXES = 3;
    localparam int OUT_AXES  = 5;    // gyro x, y, z and accel x, y

    localparam int                 WINDOW_DEFAULT = 200;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 24'd60;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [SUM_W-1:0]           motion_t;
    typedef logic signed [CORR_W-1:0]   corr_t;
    typedef logic [LIMIT_W-1:0]         limit_t;
    typedef logic [COUNT_W-1:0]         count_t;

    // Word leaving the accumulate stage.
    typedef struct packed {
        logic                            calibrated;
        logic                            rejected;
        logic                            latch;
        logic [OUT_AXES-1:0][SAMPLE_W-1:0] samp;
        logic [OUT_AXES-1:0][SUM_W-1:0]    sums;
    } acc_word_t;

    // Word leaving the bias stage.
    typedef struct packed {
        logic                            calibrated;
        logic                            rejected;
        logic [OUT_AXES-1:0][SAMPLE_W-1:0] samp;
    } bias_word_t;

endpackage

// ----- sv/isbc_in_if.sv -----
// Sample channel: valid/ready handshake carrying one six-axis word.
`timescale 1ns / 1ps

interface isbc_in_if import isbc_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t gyro_x;
    sample_t gyro_y;
    sample_t gyro_z;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink   (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    output ready);
endinterface

// ----- sv/isbc_out_if.sv -----
// Result channel: valid/ready handshake carrying status and corrected axes.
`timescale 1ns / 1ps

interface isbc_out_if import isbc_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  calibrated;
    logic  window_rejected;
    corr_t gyro_x_corr;
    corr_t gyro_y_corr;
    corr_t gyro_z_corr;
    corr_t accel_x_corr;
    corr_t accel_y_corr;

    modport source (output valid, calibrated, window_rejected, gyro_x_corr, gyro_y_corr,
                    gyro_z_corr, accel_x_corr, accel_y_corr,
                    input ready);
    modport sink   (input valid, calibrated, window_rejected, gyro_x_corr, gyro_y_corr,
                    gyro_z_corr, accel_x_corr, accel_y_corr,
                    output ready);
endinterface

// ----- sv/isbc_accum.sv -----
// Accumulate stage: window sums, gyro motion sums, window decision and calibrated flag.
`timescale 1ns / 1ps

module isbc_accum import isbc_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    isbc_in_if.sink       sample,
    input  limit_t        motion_limit,
    input  logic          advance,
    output logic          acc_valid,
    output acc_word_t     acc_word
);

    logic      done_reg, done_next;
    logic      have_prev_reg, have_prev_next;
    count_t    count_reg, count_next;
    sum_t      sums_reg [OUT_AXES];
    sum_t      sums_next [OUT_AXES];
    motion_t   motion_reg [GYRO_AXES];
    motion_t   motion_next [GYRO_AXES];
    sample_t   prev_reg [GYRO_AXES];
    sample_t   prev_next [GYRO_AXES];
    logic      valid_reg;
    acc_word_t word_reg, word_next;

    logic      accept;
    sample_t   samp [OUT_AXES];
    sum_t      sum_acc [OUT_AXES];
    motion_t   motion_acc [GYRO_AXES];
    logic [CORR_W-1:0] diff [GYRO_AXES];
    logic [CORR_W-1:0] abs_diff [GYRO_AXES];
    count_t    count_acc;
    logic      win_end;
    logic      moved;
    logic      rejected;
    logic      latch;

    assign sample.ready = advance;
    assign accept       = sample.valid && advance;

    assign samp[0] = sample.gyro_x;
    assign samp[1] = sample.gyro_y;
    assign samp[2] = sample.gyro_z;
    assign samp[3] = sample.accel_x;
    assign samp[4] = sample.accel_y;

    always_comb
    begin
        for (int k = 0; k < OUT_AXES; k++)
        begin
            sum_acc[k] = sums_reg[k] + SUM_W'(samp[k]);
        end
        moved = 1'b0;
        for (int k = 0; k < GYRO_AXES; k++)
        begin
            diff[k]     = CORR_W'(prev_reg[k]) - CORR_W'(samp[k]);
            abs_diff[k] = diff[k][CORR_W-1] ? (~diff[k] + 1'b1) : diff[k];
            // first sample after reset has nothing to compare against
            motion_acc[k] = have_prev_reg ? (motion_reg[k] + SUM_W'(abs_diff[k]))
                                          : motion_reg[k];
            if (motion_acc[k] >= SUM_W'(motion_limit))
            begin
                moved = 1'b1;
            end
        end
        count_acc = count_reg + 1'b1;
        win_end   = !done_reg && (count_acc >= COUNT_W'(WINDOW));
        rejected  = win_end && moved;
        latch     = win_end && !moved;

        done_next      = done_reg;
        have_prev_next = have_prev_reg;
        count_next     = count_reg;
        sums_next      = sums_reg;
        motion_next    = motion_reg;
        prev_next      = prev_reg;
        if (accept && !done_reg)
        begin
            have_prev_next = 1'b1;
            done_next      = latch;
            for (int k = 0; k < GYRO_AXES; k++)
            begin
                prev_next[k] = samp[k];
            end
            if (win_end)
            begin
                count_next = '0;
                for (int k = 0; k < OUT_AXES; k++)
                begin
                    sums_next[k] = '0;
                end
                for (int k = 0; k < GYRO_AXES; k++)
                begin
                    motion_next[k] = '0;
                end
            end
            else
            begin
                count_next  = count_acc;
                sums_next   = sum_acc;
                motion_next = motion_acc;
            end
        end

        word_next.calibrated = done_reg || latch;
        word_next.rejected   = rejected;
        word_next.latch      = latch;
        for (int k = 0; k < OUT_AXES; k++)
        begin
            word_next.samp[k] = samp[k];
            word_next.sums[k] = sum_acc[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            count_reg     <= '0;
            valid_reg     <= 1'b0;
            for (int k = 0; k < OUT_AXES; k++)
            begin
                sums_reg[k] <= '0;
            end
            for (int k = 0; k < GYRO_AXES; k++)
            begin
                motion_reg[k] <= '0;
                prev_reg[k]   <= '0;
            end
        end
        else
        begin
            done_reg      <= done_next;
            have_prev_reg <= have_prev_next;
            count_reg     <= count_next;
            sums_reg      <= sums_next;
            motion_reg    <= motion_next;
            prev_reg      <= prev_next;
            if (advance)
            begin
                valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign acc_valid = valid_reg;
    assign acc_word  = word_reg;

endmodule

// ----- sv/isbc_bias.sv -----
// Bias stage: window averages by reciprocal multiply, bias registers, word hold.
`timescale 1ns / 1ps

module isbc_bias import isbc_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc_valid,
    input  acc_word_t                     acc_word,
    input  logic                          advance,
    output logic                          bias_valid,
    output bias_word_t                    bias_word,
    output logic [OUT_AXES-1:0][SAMPLE_W-1:0] bias
);

    localparam int RECIP_W = MAG_W + 1;
    localparam int SHIFT   = MAG_W + $clog2(WINDOW);
    // ceil(2**SHIFT / WINDOW): exact floor division for any dividend below 2**MAG_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int PROD_W = MAG_W + RECIP_W;

    logic                              valid_reg;
    bias_word_t                        word_reg;
    logic [OUT_AXES-1:0][SAMPLE_W-1:0] bias_reg, bias_next;

    logic [SUM_W-1:0]  abs_sum [OUT_AXES];
    logic [MAG_W-1:0]  mag [OUT_AXES];
    logic [PROD_W-1:0] prod [OUT_AXES];
    logic [MAG_W-1:0]  quot [OUT_AXES];
    logic [MAG_W-1:0]  quot_s [OUT_AXES];
    logic              load;

    assign load = acc_valid && advance;

    always_comb
    begin
        bias_next = bias_reg;
        for (int k = 0; k < OUT_AXES; k++)
        begin
            abs_sum[k] = acc_word.sums[k][SUM_W-1] ? (~acc_word.sums[k] + 1'b1)
                                                   : acc_word.sums[k];
            mag[k]     = abs_sum[k][MAG_W-1:0];
            prod[k]    = PROD_W'(mag[k]) * PROD_W'(RECIP);
            quot[k]    = MAG_W'(prod[k] >> SHIFT);
            // truncate toward zero: divide the magnitude, then restore the sign
            quot_s[k]  = acc_word.sums[k][SUM_W-1] ? (~quot[k] + 1'b1) : quot[k];
            if (load && acc_word.latch)
            begin
                bias_next[k] = quot_s[k][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            bias_reg  <= '0;
        end
        else
        begin
            bias_reg <= bias_next;
            if (advance)
            begin
                valid_reg <= acc_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg.calibrated <= acc_word.calibrated;
            word_reg.rejected   <= acc_word.rejected;
            word_reg.samp       <= acc_word.samp;
        end
    end

    assign bias_valid = valid_reg;
    assign bias_word  = word_reg;
    assign bias       = bias_reg;

endmodule

// ----- sv/isbc_correct.sv -----
// Correction stage: subtract stored biases and hold the result word for the sink.
`timescale 1ns / 1ps

module isbc_correct import isbc_pkg::*; (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              bias_valid,
    input  bias_word_t                        bias_word,
    input  logic [OUT_AXES-1:0][SAMPLE_W-1:0] bias,
    output logic                              free,
    isbc_out_if.source                        result
);

    logic  valid_reg, valid_next;
    logic  cal_reg;
    logic  rej_reg;
    corr_t corr_reg [OUT_AXES];
    corr_t corr_next [OUT_AXES];

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = bias_valid;
        end
        for (int k = 0; k < OUT_AXES; k++)
        begin
            corr_next[k] = CORR_W'($signed(bias_word.samp[k])) - CORR_W'($signed(bias[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free)
        begin
            cal_reg  <= bias_word.calibrated;
            rej_reg  <= bias_word.rejected;
            corr_reg <= corr_next;
        end
    end

    assign result.valid           = valid_reg;
    assign result.calibrated      = cal_reg;
    assign result.window_rejected = rej_reg;
    assign result.gyro_x_corr     = corr_reg[0];
    assign result.gyro_y_corr     = corr_reg[1];
    assign result.gyro_z_corr     = corr_reg[2];
    assign result.accel_x_corr    = corr_reg[3];
    assign result.accel_y_corr    = corr_reg[4];

endmodule

// ----- sv/imu_still_bias_calibration_unit.sv -----
// An accepted word is registered by the accumulate, bias and correct stages.
// Throughput: one word per cycle; the three-stage valid pipeline (accumulate, bias
// divide, correct) stalls only when the result register is full and not taken.
// Reset: motion limit returns to 60, sums, counts, previous gyro and biases clear,
// calibrated drops; the block takes words in the first cycle after reset.
`timescale 1ns / 1ps

module imu_still_bias_calibration_unit import isbc_pkg::*; #(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  limit_t      cfg_wr_data,
    isbc_in_if.sink     sample,
    isbc_out_if.source  result
);

    limit_t     limit_reg, limit_next;
    logic       acc_valid;
    acc_word_t  acc_word;
    logic       bias_valid;
    bias_word_t bias_word;
    logic [OUT_AXES-1:0][SAMPLE_W-1:0] bias;
    logic       out_free;
    logic       bias_adv;
    logic       acc_adv;

    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // advance a stage when it is empty or the stage after it moves
    assign bias_adv = !bias_valid || out_free;
    assign acc_adv  = !acc_valid || bias_adv;

    isbc_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .motion_limit (limit_reg),
        .advance      (acc_adv),
        .acc_valid    (acc_valid),
        .acc_word     (acc_word)
    );

    isbc_bias #(
        .WINDOW (WINDOW)
    ) u_bias (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_valid  (acc_valid),
        .acc_word   (acc_word),
        .advance    (bias_adv),
        .bias_valid (bias_valid),
        .bias_word  (bias_word),
        .bias       (bias)
    );

    isbc_correct u_correct (
        .clk        (clk),
        .rst_n      (rst_n),
        .bias_valid (bias_valid),
        .bias_word  (bias_word),
        .bias       (bias),
        .free       (out_free),
        .result     (result)
    );

endmodule

// ----- dv/tb_imu_still_bias_calibration_unit.sv -----
// Self-checking bench for the IMU still-bias calibration unit: directed table, then window runs.
`timescale 1ns / 1ps

module tb_imu_still_bias_calibration_unit;
    import isbc_pkg::*;

    localparam int     WIN         = WINDOW_DEFAULT;
    localparam int     LATENCY     = 3;
    localparam int     SETTLE      = LATENCY + 5;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     N_DIR       = 16;
    localparam int     NOISE_ITEMS = 384;
    localparam int     TAIL_ITEMS  = 350;
    localparam int     CALM_ITEMS  = 150;
    localparam limit_t LIMIT_MAX   = '1;

    typedef enum int {NOISE_FULL, NOISE_JITTER, NOISE_RAILS} noise_mode_t;

    typedef struct packed {
        sample_t [0:2] gyro;
        sample_t [0:2] accel;
    } imu_word_t;

    typedef struct packed {
        logic        calibrated;
        logic        rejected;
        corr_t [0:4] corr;      // gyro x, y, z, accel x, y
    } corr_word_t;

    typedef struct packed {
        imu_word_t  stim;
        corr_word_t want;
    } dir_row_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_wr_en;
    limit_t cfg_wr_data;

    isbc_in_if  smp_if ();
    isbc_out_if res_if ();

    imu_still_bias_calibration_unit #(
        .WINDOW (WIN)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (smp_if),
        .result      (res_if)
    );

    // Local copy of the calibration state.
    limit_t  limit_now;
    logic    cal_done;
    count_t  win_count;
    sum_t    axis_acc   [6];
    motion_t motion_acc [3];
    sample_t last_gyro  [3];
    logic    have_last;
    sample_t bias_est   [6];

    corr_word_t corr_pending [$];
    int         err_count = 0;
    int         word_idx  = 0;
    bit         idle_en   = 1'b0;
    string      corr_name [5] = '{"gyro_x_corr", "gyro_y_corr", "gyro_z_corr",
                                  "accel_x_corr", "accel_y_corr"};
    sample_t    rail_val  [4] = '{-32768, 32767, 0, -1};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic corr_word_t bias_track_step(imu_word_t w);
        corr_word_t r;
        int         s [6];
        int         d;
        int         k;
        for (k = 0; k < 3; k++)
        begin
            s[k]     = $signed(w.gyro[k]);
            s[k + 3] = $signed(w.accel[k]);
        end
        r.rejected = 1'b0;
        if (!cal_done)
        begin
            for (k = 0; k < 6; k++)
                axis_acc[k] = axis_acc[k] + sum_t'(s[k]);
            // the first word after reset has nothing to diff against
            for (k = 0; k < 3; k++)
            begin
                if (have_last)
                begin
                    d = $signed(last_gyro[k]) - s[k];
                    motion_acc[k] = motion_acc[k] + motion_t'((d < 0) ? -d : d);
                end
                last_gyro[k] = sample_t'(s[k]);
            end
            have_last = 1'b1;
            win_count = win_count + 1'b1;
            if (int'(win_count) >= WIN)
            begin
                if (motion_acc[0] >= limit_now || motion_acc[1] >= limit_now ||
                    motion_acc[2] >= limit_now)
                    r.rejected = 1'b1;
                else
                begin
                    // average truncates toward zero
                    for (k = 0; k < 6; k++)
                    begin
                        d = $signed(axis_acc[k]);
                        bias_est[k] = sample_t'(d / WIN);
                    end
                    cal_done = 1'b1;
                end
                win_count = '0;
                for (k = 0; k < 6; k++)
                    axis_acc[k] = '0;
                for (k = 0; k < 3; k++)
                    motion_acc[k] = '0;
            end
        end
        r.calibrated = cal_done;
        for (k = 0; k < 5; k++)
            r.corr[k] = corr_t'(s[k] - $signed(bias_est[k]));
        return r;
    endfunction

    function automatic imu_word_t noise_word(noise_mode_t mode);
        imu_word_t w;
        int        v;
        int        k;
        w = {$urandom, $urandom, $urandom};
        case (mode)
            NOISE_JITTER:
                for (k = 0; k < 3; k++)
                begin
                    v = $signed(last_gyro[k]) + int'($urandom_range(0, 6)) - 3;
                    if (v > 32767)
                        v = 32767;
                    else if (v < -32768)
                        v = -32768;
                    w.gyro[k] = sample_t'(v);
                end
            NOISE_RAILS:
                for (k = 0; k < 3; k++)
                begin
                    w.gyro[k]  = rail_val[$urandom_range(0, 3)];
                    w.accel[k] = rail_val[$urandom_range(0, 3)];
                end
            default:
                ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        $display("%0t word %0d %s: got %0d, want %0d", $time, word_idx, what, got, want);
    endtask

    task automatic send_word(imu_word_t w, bit typed = 1'b0, corr_word_t want = '0);
        corr_word_t pred;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        smp_if.valid   <= 1'b1;
        smp_if.gyro_x  <= w.gyro[0];
        smp_if.gyro_y  <= w.gyro[1];
        smp_if.gyro_z  <= w.gyro[2];
        smp_if.accel_x <= w.accel[0];
        smp_if.accel_y <= w.accel[1];
        smp_if.accel_z <= w.accel[2];
        @(posedge clk);
        while (smp_if.ready !== 1'b1)
            @(posedge clk);
        pred = bias_track_step(w);
        corr_pending.push_back(typed ? want : pred);
    endtask

    // Drain the pipe, then write the limit while the block sits idle.
    task automatic write_motion_limit(limit_t value);
        smp_if.valid <= 1'b0;
        while (corr_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now = value;
    endtask

    // One full window: gyro holds, then each axis steps once so its motion sum is exact.
    task automatic motion_window(int hot_axis, int step);
        imu_word_t w;
        int        from [3];
        int        to   [3];
        int        amt;
        int        at;
        int        i;
        int        k;
        idle_en = ($urandom_range(0, 3) != 0);
        at = $urandom_range(0, WIN - 1);
        for (k = 0; k < 3; k++)
        begin
            amt     = (k == hot_axis) ? step : ((step > 0) ? step - 1 : 0);
            from[k] = $signed(last_gyro[k]);
            to[k]   = (from[k] + amt <= 32767) ? from[k] + amt : from[k] - amt;
        end
        for (i = 0; i < WIN; i++)
        begin
            w = noise_word(NOISE_FULL);
            for (k = 0; k < 3; k++)
                w.gyro[k] = sample_t'((i < at) ? from[k] : to[k]);
            send_word(w);
        end
    endtask

    initial
    begin : result_sink
        corr_word_t  want;
        corr_t [0:4] got;
        int          stall_left;
        int          k;
        stall_left = 0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                got = {res_if.gyro_x_corr, res_if.gyro_y_corr, res_if.gyro_z_corr,
                       res_if.accel_x_corr, res_if.accel_y_corr};
                if (corr_pending.size() == 0)
                    report_mismatch("word with nothing expected", 0, 0);
                else
                begin
                    want = corr_pending.pop_front();
                    if (res_if.calibrated !== want.calibrated)
                        report_mismatch("calibrated", res_if.calibrated, want.calibrated);
                    if (res_if.window_rejected !== want.rejected)
                        report_mismatch("window_rejected", res_if.window_rejected,
                                        want.rejected);
                    for (k = 0; k < 5; k++)
                        if (got[k] !== want.corr[k])
                            report_mismatch(corr_name[k], $signed(got[k]),
                                            $signed(want.corr[k]));
                end
                word_idx++;
            end
            if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t  dir_tab [N_DIR];
        imu_word_t w;
        int        n;
        int        i;
        int        k;
        int        lim;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.gyro_x  <= '0;
        smp_if.gyro_y  <= '0;
        smp_if.gyro_z  <= '0;
        smp_if.accel_x <= '0;
        smp_if.accel_y <= '0;
        smp_if.accel_z <= '0;

        limit_now = LIMIT_RESET;
        cal_done  = 1'b0;
        have_last = 1'b0;
        win_count = '0;
        for (k = 0; k < 6; k++)
        begin
            axis_acc[k] = '0;
            bias_est[k] = '0;
        end
        for (k = 0; k < 3; k++)
        begin
            motion_acc[k] = '0;
            last_gyro[k]  = '0;
        end

        // gyro x,y,z / accel x,y,z -> calibrated, rejected, corrected gx,gy,gz,ax,ay.
        // All land inside the first window: biases are still zero, so corrected == raw.
        dir_tab = '{
            '{'{'{0, 0, 0}, '{0, 0, 0}},
              '{1'b0, 1'b0, '{0, 0, 0, 0, 0}}},
            '{'{'{32767, 32767, 32767}, '{32767, 32767, 32767}},
              '{1'b0, 1'b0, '{32767, 32767, 32767, 32767, 32767}}},
            '{'{'{-32768, -32768, -32768}, '{-32768, -32768, -32768}},
              '{1'b0, 1'b0, '{-32768, -32768, -32768, -32768, -32768}}},
            '{'{'{32767, -32768, 32767}, '{-32768, 32767, -32768}},
              '{1'b0, 1'b0, '{32767, -32768, 32767, -32768, 32767}}},
            '{'{'{-32768, 32767, -32768}, '{32767, -32768, 32767}},
              '{1'b0, 1'b0, '{-32768, 32767, -32768, 32767, -32768}}},
            '{'{'{21845, -21846, 21845}, '{-21846, 21845, -21846}},
              '{1'b0, 1'b0, '{21845, -21846, 21845, -21846, 21845}}},
            '{'{'{-21846, 21845, -21846}, '{21845, -21846, 21845}},
              '{1'b0, 1'b0, '{-21846, 21845, -21846, 21845, -21846}}},
            '{'{'{1, -1, 1}, '{-1, 1, -1}},
              '{1'b0, 1'b0, '{1, -1, 1, -1, 1}}},
            '{'{'{-1, 1, -1}, '{1, -1, 1}},
              '{1'b0, 1'b0, '{-1, 1, -1, 1, -1}}},
            '{'{'{256, -256, 4096}, '{-4096, 16384, -16384}},
              '{1'b0, 1'b0, '{256, -256, 4096, -4096, 16384}}},
            '{'{'{-1, -1, -1}, '{-1, -1, -1}},
              '{1'b0, 1'b0, '{-1, -1, -1, -1, -1}}},
            '{'{'{1, 1, 1}, '{1, 1, 1}},
              '{1'b0, 1'b0, '{1, 1, 1, 1, 1}}},
            '{'{'{32767, 0, -32768}, '{0, 32767, -32768}},
              '{1'b0, 1'b0, '{32767, 0, -32768, 0, 32767}}},
            '{'{'{-32768, 32767, 0}, '{32767, -32768, 0}},
              '{1'b0, 1'b0, '{-32768, 32767, 0, 32767, -32768}}},
            '{'{'{100, -100, 7}, '{12345, -12345, 0}},
              '{1'b0, 1'b0, '{100, -100, 7, 12345, -12345}}},
            '{'{'{0, 0, 0}, '{0, 0, 0}},
              '{1'b0, 1'b0, '{0, 0, 0, 0, 0}}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        idle_en = 1'b1;
        for (i = 0; i < N_DIR; i++)
            send_word(dir_tab[i].stim, 1'b1, dir_tab[i].want);

        // Moving sensor at the reset limit: every window should get thrown out.
        n = 0;
        while (n < NOISE_ITEMS)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            k = $urandom_range(0, 2);
            for (i = $urandom_range(8, 40); i > 0 && n < NOISE_ITEMS; i--)
            begin
                send_word(noise_word(noise_mode_t'(k)));
                n++;
            end
        end

        // Zero limit rejects even a perfectly still window.
        write_motion_limit('0);
        while (win_count != 0)
        begin
            w = noise_word(NOISE_FULL);
            w.gyro = {last_gyro[0], last_gyro[1], last_gyro[2]};
            send_word(w);
        end
        motion_window(0, 0);

        // Motion sum lands exactly on the limit on one axis, one below on the others.
        write_motion_limit(limit_t'(1));
        motion_window(0, 1);
        lim = $urandom_range(2, 3000);
        write_motion_limit(limit_t'(lim));
        motion_window(1, lim);
        lim = $urandom_range(2, 3000);
        write_motion_limit(limit_t'(lim));
        motion_window(2, lim);

        // Full-scale limit lets a rail-to-rail window through and latches the biases.
        write_motion_limit(LIMIT_MAX);
        idle_en = 1'b1;
        for (i = 0; i < WIN; i++)
        begin
            w = noise_word(NOISE_FULL);
            w.gyro[0]  = (i % 2 == 0) ? 32767 : -32768;
            w.gyro[1]  = 32767;
            w.gyro[2]  = -32768;
            w.accel[0] = -32768;
            w.accel[1] = 32767;
            send_word(w);
        end

        // Calibrated: only the correction runs from here on.
        write_motion_limit(LIMIT_RESET);
        for (i = 0; i < TAIL_ITEMS; i++)
        begin
            if (i % 25 == 0)
                idle_en = (i < TAIL_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            send_word(noise_word(noise_mode_t'($urandom_range(0, 2))));
        end
        smp_if.valid <= 1'b0;

        while (corr_pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0 && corr_pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/isbc_pkg.sv
sv/isbc_in_if.sv
sv/isbc_out_if.sv
sv/isbc_accum.sv
sv/isbc_bias.sv
sv/isbc_correct.sv
sv/imu_still_bias_calibration_unit.sv
dv/tb_imu_still_bias_calibration_unit.sv
